// ===== rtl/core/cjt_pkg.sv =====
// Package: shared constants and limit functions for the cubic trajectory unit.
`timescale 1ns / 1ps
`default_nettype none
package cjt_pkg;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
	localparam int TIME_W = 26;
	localparam int S_BITS = 24;
	localparam int MAX_JOINTS = 7;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_REJECTED = 2'd1;
	localparam logic [1:0] ST_COMMAND  = 2'd2;
	localparam logic [1:0] ST_IDLE     = 2'd3;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [TIME_W-1:0] MIN_DUR_RESET = 26'd1000000;

	// joint limits in units of 1e-4 rad
	function automatic int lim_lo_e4(input int j);
		case (j)
			0: return -28973;
			1: return -17628;
			2: return -28973;
			3: return -30718;
			4: return -28973;
			5: return -175;
			6: return -28973;
			default: return 0;
		endcase
	endfunction

	function automatic int lim_hi_e4(input int j);
		case (j)
			0: return 28973;
			1: return 17628;
			2: return 28973;
			3: return -698;
			4: return 28973;
			5: return 37525;
			6: return 28973;
			default: return 0;
		endcase
	endfunction

	// e4 * 2^fb / 10000, rounded half away from zero; elaboration only
	function automatic longint limit_fixed(input int e4, input int fb);
		longint m;
		longint r;
		m = (e4 < 0) ? -longint'(e4) : longint'(e4);
		r = ((m << fb) + 64'sd5000) / 64'sd10000;
		return (e4 < 0) ? -r : r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/cjt_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface cjt_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic signed [18:0] angle_one;
	logic signed [18:0] angle_two;
	logic signed [18:0] angle_three;
	logic signed [18:0] angle_four;
	logic signed [18:0] angle_five;
	logic signed [18:0] angle_six;
	logic signed [18:0] angle_seven;
	logic [25:0] time_value_us;
	logic        has_duration;
	modport source (output valid, opcode, angle_one, angle_two, angle_three, angle_four,
		angle_five, angle_six, angle_seven, time_value_us, has_duration, input ready);
	modport sink (input valid, opcode, angle_one, angle_two, angle_three, angle_four,
		angle_five, angle_six, angle_seven, time_value_us, has_duration, output ready);
endinterface

interface cjt_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic signed [18:0] cmd_one;
	logic signed [18:0] cmd_two;
	logic signed [18:0] cmd_three;
	logic signed [18:0] cmd_four;
	logic signed [18:0] cmd_five;
	logic signed [18:0] cmd_six;
	logic signed [18:0] cmd_seven;
	logic        finished;
	logic [2:0]  rejected_joint;
	modport source (output valid, status, cmd_one, cmd_two, cmd_three, cmd_four, cmd_five,
		cmd_six, cmd_seven, finished, rejected_joint, input ready);
	modport sink (input valid, status, cmd_one, cmd_two, cmd_three, cmd_four, cmd_five,
		cmd_six, cmd_seven, finished, rejected_joint, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cjt_divider.sv =====
// Restoring divider: floor((num << 24) / den) for num < den, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cjt_divider (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [cjt_pkg::TIME_W-1:0] num,
	input  wire logic [cjt_pkg::TIME_W-1:0] den,
	output logic busy,
	output logic [cjt_pkg::S_BITS:0] quot
);
	import cjt_pkg::*;
	localparam int STEPS = S_BITS;
	localparam int CW = $clog2(STEPS + 1);

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [TIME_W:0] shifted;
	logic [TIME_W:0] trial;
	logic take;

	// remainder stays below den, so the doubled value fits in TIME_W+1 bits
	assign shifted = {rem_q, 1'b0};
	assign take = shifted >= {1'b0, den_q};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= CW'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quot <= '0;
		end else if (busy) begin
			rem_q <= take ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
			quot <= {quot[S_BITS-1:0], take};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/cjt_mac.sv =====
// Shared multiplier with rounding: computes (a * b + 2^23) >> 24.
`timescale 1ns / 1ps
`default_nettype none
module cjt_mac (
	input  wire logic clk,
	input  wire logic [cjt_pkg::S_BITS+1:0] a,
	input  wire logic [cjt_pkg::S_BITS+1:0] b,
	output logic [cjt_pkg::S_BITS+1:0] p
);
	import cjt_pkg::*;
	localparam int W = S_BITS + 2;
	logic [2*W-1:0] prod_s1;

	always_ff @(posedge clk) prod_s1 <= a * b;

	logic [2*W-1:0] rnd;
	assign rnd = prod_s1 + (2*W)'(1 << (S_BITS - 1));
	assign p = rnd[S_BITS +: W];
endmodule
`default_nettype wire

// ===== rtl/core/cubic_joint_trajectory_unit.sv =====
// Top level of the cubic joint trajectory unit: sequencer, state and result register.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves on res.
// A start request (opcode 0) checks targets against fixed joint limits; the result
// register loads in the cycle after acceptance. An idle tick (no move running) loads it
// at the accepting edge. A moving tick runs a 24-step serial divide for s = t/tf, two
// shared multiplies for the cubic blend and one shared multiply per joint; the result
// loads after the last joint, and the divide is skipped when the move is complete.
// Throughput is one request per result: ready is low from acceptance until the result
// has been taken and returns the cycle after; a stalled receiver holds the block.
// cfg_we writes min_duration_us; write only while idle.
// Reset clears the move state, sets min_duration_us to 1000000 and empties the
// result register. Start and target angle stores are not reset.
`timescale 1ns / 1ps
`default_nettype none
module cubic_joint_trajectory_unit #(
	parameter int JOINT_COUNT = 7
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cjt_req_if.sink req,
	cjt_res_if.source res,
	input  wire logic cfg_we,
	input  wire logic [cjt_pkg::TIME_W-1:0] cfg_wdata
);
	import cjt_pkg::*;
	localparam int AW = ANGLE_W;
	localparam int SW = S_BITS + 2;
	localparam int JW = 3;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIV   = 7'b0000010,
		S_SQ    = 7'b0000100,
		S_BLEND = 7'b0001000,
		S_JOINT = 7'b0010000,
		S_CHECK = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [TIME_W-1:0] min_dur_q, elapsed_q, dur_q;
	logic moving_q, await_q;
	logic signed [AW-1:0] start_q [MAX_JOINTS];
	logic signed [AW-1:0] target_q [MAX_JOINTS];
	logic signed [AW-1:0] ang_q [MAX_JOINTS];
	logic signed [AW-1:0] cmd_q [MAX_JOINTS];
	logic [JW-1:0] jidx_q;
	logic [1:0] phase_q;
	logic [SW-1:0] s_q, s2_q, h_q;
	logic done_q;
	logic [1:0] status_q;
	logic fin_q;
	logic [2:0] rej_q;
	logic res_valid_q;
	logic has_dur_q;
	logic [TIME_W-1:0] tv_q;

	logic signed [AW-1:0] ang_in [MAX_JOINTS];
	assign ang_in[0] = req.angle_one;
	assign ang_in[1] = req.angle_two;
	assign ang_in[2] = req.angle_three;
	assign ang_in[3] = req.angle_four;
	assign ang_in[4] = req.angle_five;
	assign ang_in[5] = req.angle_six;
	assign ang_in[6] = req.angle_seven;

	logic [MAX_JOINTS-1:0] bad;
	always_comb begin
		for (int j = 0; j < MAX_JOINTS; j++) begin
			bad[j] = (j < JOINT_COUNT) &&
				((longint'(ang_q[j]) < limit_fixed(lim_lo_e4(j), ANGLE_FRAC_BITS)) ||
				 (longint'(ang_q[j]) > limit_fixed(lim_hi_e4(j), ANGLE_FRAC_BITS)));
		end
	end
	logic [2:0] first_bad;
	always_comb begin
		first_bad = 3'd0;
		for (int j = MAX_JOINTS - 1; j >= 0; j--)
			if (bad[j]) first_bad = 3'(j + 1);
	end

	logic accept;
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && !res_valid_q;

	logic [TIME_W:0] el_sum;
	assign el_sum = {1'b0, elapsed_q} + {1'b0, req.time_value_us};

	// divider
	logic div_start, div_busy;
	logic [S_BITS:0] div_quot;
	cjt_divider u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(elapsed_q),
		.den(dur_q), .busy(div_busy), .quot(div_quot));

	// shared multiplier; joint multiply uses magnitude of delta
	logic [SW-1:0] mul_a, mul_b, mul_p;
	cjt_mac u_mac (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	logic signed [AW:0] delta;
	logic [AW:0] dmag;
	assign delta = {target_q[jidx_q][AW-1], target_q[jidx_q]} -
		{start_q[jidx_q][AW-1], start_q[jidx_q]};
	assign dmag = delta[AW] ? (AW+1)'(-delta) : (AW+1)'(delta);

	logic [SW-1:0] three_m2s;
	assign three_m2s = SW'(3 << S_BITS) - {s_q[SW-2:0], 1'b0};

	always_comb begin
		case (state_q)
			S_SQ: begin
				mul_a = s_q;
				mul_b = s_q;
			end
			S_BLEND: begin
				mul_a = s2_q;
				mul_b = three_m2s;
			end
			S_JOINT: begin
				mul_a = SW'(dmag);
				mul_b = h_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	logic signed [AW:0] off;
	assign off = delta[AW] ? -$signed((AW+1)'(mul_p)) : $signed((AW+1)'(mul_p));
	logic [AW:0] qsum;
	assign qsum = (AW+1)'({start_q[jidx_q][AW-1], start_q[jidx_q]} + off);

	assign div_start = (state_q == S_DIV) && (phase_q == 2'd0) && !done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			min_dur_q <= MIN_DUR_RESET;
			elapsed_q <= '0;
			dur_q <= '0;
			moving_q <= 1'b0;
			await_q <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q <= '0;
			jidx_q <= '0;
		end else begin
			if (cfg_we) min_dur_q <= cfg_wdata;
			if (res_valid_q && res.ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) begin
					if (req.opcode == OP_START) begin
						state_q <= S_CHECK;
					end else if (!moving_q) begin
						res_valid_q <= 1'b1;
					end else begin
						await_q <= 1'b0;
						elapsed_q <= el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
						phase_q <= 2'd0;
						state_q <= S_DIV;
					end
				end
				S_CHECK: begin
					if (first_bad == 3'd0) begin
						dur_q <= (has_dur_q && tv_q > min_dur_q) ? tv_q : min_dur_q;
						elapsed_q <= '0;
						moving_q <= 1'b1;
						await_q <= 1'b1;
					end
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DIV: begin
					if (phase_q == 2'd0) phase_q <= 2'd1;
					else if (done_q || !div_busy) begin
						phase_q <= 2'd0;
						state_q <= S_SQ;
					end
				end
				S_SQ, S_BLEND: begin
					if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						phase_q <= 2'd0;
						state_q <= (state_q == S_SQ) ? S_BLEND : S_JOINT;
						jidx_q <= '0;
					end
				end
				S_JOINT: begin
					if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						phase_q <= 2'd0;
						if (32'(jidx_q) == JOINT_COUNT - 1) state_q <= S_OUT;
						else jidx_q <= jidx_q + 1'b1;
					end
				end
				S_OUT: begin
					if (done_q) moving_q <= 1'b0;
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				for (int j = 0; j < MAX_JOINTS; j++) ang_q[j] <= ang_in[j];
				has_dur_q <= req.has_duration;
				tv_q <= req.time_value_us;
				status_q <= (req.opcode == OP_START) ? ST_ACCEPTED : ST_IDLE;
				fin_q <= 1'b0;
				rej_q <= 3'd0;
				for (int j = 0; j < MAX_JOINTS; j++) cmd_q[j] <= '0;
				if (req.opcode == OP_TICK && moving_q && await_q)
					for (int j = 0; j < MAX_JOINTS; j++) start_q[j] <= ang_in[j];
				done_q <= (el_sum[TIME_W] ? {TIME_W{1'b1}} : el_sum[TIME_W-1:0]) >= dur_q;
			end
			S_CHECK: begin
				if (first_bad == 3'd0) begin
					for (int j = 0; j < MAX_JOINTS; j++) target_q[j] <= ang_q[j];
				end else begin
					status_q <= ST_REJECTED;
					rej_q <= first_bad;
				end
			end
			S_DIV: if (phase_q != 2'd0 && (done_q || !div_busy))
				s_q <= done_q ? SW'(1 << S_BITS) : SW'(div_quot);
			S_SQ: if (phase_q != 2'd0) s2_q <= mul_p;
			S_BLEND: if (phase_q != 2'd0) h_q <= mul_p;
			S_JOINT: if (phase_q != 2'd0) cmd_q[jidx_q] <= qsum[AW-1:0];
			S_OUT: begin
				status_q <= ST_COMMAND;
				fin_q <= done_q;
			end
			default: ;
		endcase
	end

	assign res.valid = res_valid_q;
	assign res.status = status_q;
	assign res.cmd_one = cmd_q[0];
	assign res.cmd_two = cmd_q[1];
	assign res.cmd_three = cmd_q[2];
	assign res.cmd_four = cmd_q[3];
	assign res.cmd_five = cmd_q[4];
	assign res.cmd_six = cmd_q[5];
	assign res.cmd_seven = cmd_q[6];
	assign res.finished = fin_q;
	assign res.rejected_joint = rej_q;
endmodule
`default_nettype wire

// ===== rtl/core/cjt_checker.sv =====
// Port-level assertions for the cubic joint trajectory unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cjt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic [1:0] res_status,
	input wire logic res_finished,
	input wire logic [2:0] res_rejected_joint
);
	import cjt_pkg::*;
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result dropped");
	// no new request while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready) else $error("ready with pending result");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_finished |-> res_status == ST_COMMAND) else $error("bad finish");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_rejected_joint != 3'd0) == (res_status == ST_REJECTED)))
		else $error("bad reject code");
endmodule

bind cubic_joint_trajectory_unit cjt_checker u_chk (.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready), .res_valid(res.valid),
	.res_ready(res.ready), .res_status(res.status), .res_finished(res.finished),
	.res_rejected_joint(res.rejected_joint));
`default_nettype wire

// ===== sim/cjt_checker.sv =====
// Checker: predicts trajectory results from accepted requests and compares them.
`timescale 1ns / 1ps
`default_nettype none
module cjt_result_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [cjt_pkg::TIME_W-1:0] cfg_wdata,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  wire logic req_opcode,
	input  wire logic signed [cjt_pkg::ANGLE_W-1:0] req_angle [cjt_pkg::MAX_JOINTS],
	input  wire logic [cjt_pkg::TIME_W-1:0] req_time,
	input  wire logic req_has_dur,
	input  wire logic res_valid,
	input  wire logic res_ready,
	input  wire logic [1:0] res_status,
	input  wire logic signed [cjt_pkg::ANGLE_W-1:0] res_cmd [cjt_pkg::MAX_JOINTS],
	input  wire logic res_finished,
	input  wire logic [2:0] res_rej,
	output int errors,
	output int pending
);
	import cjt_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [MAX_JOINTS*ANGLE_W-1:0] cmds;
		logic finished;
		logic [2:0] rej;
	} traj_result_t;

	localparam longint S_ONE = longint'(1) << S_BITS;
	localparam longint S_HALF = longint'(1) << (S_BITS - 1);
	localparam longint T_MAX = (longint'(1) << TIME_W) - 1;

	traj_result_t expected_q[$];
	longint min_dur, dur, elapsed;
	longint q_start[MAX_JOINTS], q_goal[MAX_JOINTS];
	bit moving, first_tick;

	function automatic longint lim_fix(int e4);
		longint m, r;
		m = (e4 < 0) ? -longint'(e4) : longint'(e4);
		r = ((m << ANGLE_FRAC_BITS) + 5000) / 10000;
		return (e4 < 0) ? -r : r;
	endfunction

	function automatic int lim_lo(int j);
		case (j)
			0, 2, 4, 6: return -28973;
			1: return -17628;
			3: return -30718;
			default: return -175;
		endcase
	endfunction

	function automatic int lim_hi(int j);
		case (j)
			0, 2, 4, 6: return 28973;
			1: return 17628;
			3: return -698;
			default: return 37525;
		endcase
	endfunction

	task automatic predict_trajectory;
		traj_result_t r;
		longint a[MAX_JOINTS];
		longint s, s2, h, d, m, off;
		bit done;
		r = '0;
		for (int i = 0; i < MAX_JOINTS; i++) a[i] = longint'(req_angle[i]);
		if (req_opcode == OP_START) begin
			r.status = ST_ACCEPTED;
			for (int i = 0; i < MAX_JOINTS; i++) begin
				if (a[i] < lim_fix(lim_lo(i)) || a[i] > lim_fix(lim_hi(i))) begin
					r.status = ST_REJECTED;
					r.rej = 3'(i + 1);
					break;
				end
			end
			if (r.status == ST_ACCEPTED) begin
				for (int i = 0; i < MAX_JOINTS; i++) q_goal[i] = a[i];
				dur = min_dur;
				if (req_has_dur && longint'(req_time) > dur) dur = longint'(req_time);
				elapsed = 0;
				moving = 1;
				first_tick = 1;
			end
		end else if (!moving) begin
			r.status = ST_IDLE;
		end else begin
			if (first_tick) begin
				for (int i = 0; i < MAX_JOINTS; i++) q_start[i] = a[i];
				first_tick = 0;
			end
			elapsed += longint'(req_time);
			if (elapsed > T_MAX) elapsed = T_MAX;
			done = elapsed >= dur;
			s = (done || dur == 0) ? S_ONE : (elapsed << S_BITS) / dur;
			s2 = (s * s + S_HALF) >>> S_BITS;
			h = (s2 * (3 * S_ONE - 2 * s) + S_HALF) >>> S_BITS;
			r.status = ST_COMMAND;
			for (int i = 0; i < MAX_JOINTS; i++) begin
				d = q_goal[i] - q_start[i];
				m = (d < 0) ? -d : d;
				off = (m * h + S_HALF) >>> S_BITS;
				if (d < 0) off = -off;
				r.cmds[i*ANGLE_W +: ANGLE_W] = ANGLE_W'(q_start[i] + off);
			end
			r.finished = done;
			if (done) moving = 0;
		end
		expected_q = {expected_q, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		traj_result_t got, exp_r;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			min_dur = longint'(MIN_DUR_RESET);
			dur = 0;
			elapsed = 0;
			moving = 0;
			first_tick = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) min_dur = longint'(cfg_wdata);
			if (req_valid && req_ready) predict_trajectory();
			if (res_valid && res_ready) begin
				got.status = res_status;
				for (int i = 0; i < MAX_JOINTS; i++) got.cmds[i*ANGLE_W +: ANGLE_W] = res_cmd[i];
				got.finished = res_finished;
				got.rej = res_rej;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					errors <= errors + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected st=%0d cmd=%h fin=%b rej=%0d",
							$realtime, exp_r.status, exp_r.cmds, exp_r.finished, exp_r.rej);
						$display("%0t:          actual   st=%0d cmd=%h fin=%b rej=%0d",
							$realtime, got.status, got.cmds, got.finished, got.rej);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== sim/cubic_joint_trajectory_unit_tb.sv =====
// Testbench top: drives requests, configuration and back-pressure; gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module cubic_joint_trajectory_unit_tb;
	import cjt_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [TIME_W-1:0] cfg_wdata = '0;
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 0;
	int errors, pending;

	cjt_req_if req();
	cjt_res_if res();

	logic signed [ANGLE_W-1:0] req_ang [MAX_JOINTS];
	logic signed [ANGLE_W-1:0] res_cmd [MAX_JOINTS];
	assign req_ang = '{req.angle_one, req.angle_two, req.angle_three, req.angle_four,
		req.angle_five, req.angle_six, req.angle_seven};
	assign res_cmd = '{res.cmd_one, res.cmd_two, res.cmd_three, res.cmd_four,
		res.cmd_five, res.cmd_six, res.cmd_seven};

	cubic_joint_trajectory_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	cjt_result_checker u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req.valid), .req_ready(req.ready), .req_opcode(req.opcode),
		.req_angle(req_ang), .req_time(req.time_value_us), .req_has_dur(req.has_duration),
		.res_valid(res.valid), .res_ready(res.ready), .res_status(res.status),
		.res_cmd(res_cmd), .res_finished(res.finished), .res_rej(res.rejected_joint),
		.errors(errors), .pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on demand
	always @(posedge clk) begin
		if (hold_off) res.ready <= 1'b0;
		else res.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	function automatic logic signed [ANGLE_W-1:0] rand_angle();
		case ($urandom_range(5))
			0: return $signed(19'($urandom));
			1: return 19'sh3ffff;
			2: return -19'sh40000;
			default: return 19'($signed($urandom_range(4000, 0)) - 2000) <<< 4;
		endcase
	endfunction

	// targets inside the limit window of each joint, near its edges now and then
	function automatic logic signed [ANGLE_W-1:0] legal_angle(int j);
		int lo, hi;
		case (j)
			1: begin lo = -115525; hi = 115525; end
			3: begin lo = -201313; hi = -4574; end
			5: begin lo = -1146; hi = 245923; end
			default: begin lo = -189877; hi = 189877; end
		endcase
		case ($urandom_range(9))
			0: return 19'(lo);
			1: return 19'(hi);
			default: return 19'(lo + int'($urandom_range(hi - lo)));
		endcase
	endfunction

	task automatic send_request(bit op, logic signed [ANGLE_W-1:0] a [MAX_JOINTS],
		logic [TIME_W-1:0] tv, bit hd);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		req.valid <= 1'b1; req.opcode <= op; req.time_value_us <= tv; req.has_duration <= hd;
		req.angle_one <= a[0]; req.angle_two <= a[1]; req.angle_three <= a[2];
		req.angle_four <= a[3]; req.angle_five <= a[4]; req.angle_six <= a[5];
		req.angle_seven <= a[6];
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		req.valid <= 1'b0;
		// ready is always low in the cycle after an acceptance
		@(posedge clk);
	endtask

	task automatic start_move(bit legal, logic [TIME_W-1:0] tv, bit hd);
		logic signed [ANGLE_W-1:0] a [MAX_JOINTS];
		for (int j = 0; j < MAX_JOINTS; j++) a[j] = legal ? legal_angle(j) : rand_angle();
		send_request(OP_START, a, tv, hd);
	endtask

	task automatic tick(logic [TIME_W-1:0] period);
		logic signed [ANGLE_W-1:0] a [MAX_JOINTS];
		for (int j = 0; j < MAX_JOINTS; j++) a[j] = rand_angle();
		send_request(OP_TICK, a, period, 1'($urandom_range(1)));
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_min_duration(logic [TIME_W-1:0] v);
		drain();
		cfg_we <= 1'b1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int count, int max_dur);
		int sent, n;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				// noise: bad start or stray tick
				if ($urandom_range(1) != 0)
					start_move(1'b0, 26'($urandom), 1'($urandom_range(1)));
				else tick(26'($urandom));
				sent++;
			end else begin
				start_move(1'b1, 26'($urandom_range(max_dur)), 1'($urandom_range(1)));
				n = int'($urandom_range(12, 1));
				for (int k = 0; k < n; k++)
					tick(($urandom_range(3) == 0) ? 26'($urandom) :
						26'($urandom_range(max_dur / 4)));
				sent += n + 1;
			end
		end
	endtask

	initial begin
		logic signed [ANGLE_W-1:0] a [MAX_JOINTS];
		req.valid = 1'b0; req.opcode = 1'b0; req.has_duration = 1'b0; req.time_value_us = '0;
		req.angle_one = '0; req.angle_two = '0; req.angle_three = '0; req.angle_four = '0;
		req.angle_five = '0; req.angle_six = '0; req.angle_seven = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle tick, limit violations per joint, duration choices, saturation
		tick(26'd100);
		for (int j = 0; j < MAX_JOINTS; j++) begin
			for (int k = 0; k < MAX_JOINTS; k++) a[k] = legal_angle(k);
			a[j] = (j % 2) ? 19'sh3ffff : -19'sh40000;
			send_request(OP_START, a, 26'd0, 1'b0);
		end
		start_move(1'b1, 26'd0, 1'b0);
		tick(26'd500000); tick(26'd600000);
		start_move(1'b1, 26'd2000000, 1'b1);
		tick(26'd1000); tick(26'h3ffffff); tick(26'h3ffffff);
		start_move(1'b1, 26'h3ffffff, 1'b1);
		tick(26'h3ffffff); tick(26'h3ffffff);
		start_move(1'b1, 26'd10, 1'b1);
		start_move(1'b1, 26'd0, 1'b0);
		tick(26'd1); tick(26'd0);

		set_min_duration(26'd0);
		start_move(1'b1, 26'd0, 1'b0);
		tick(26'd0);
		set_min_duration(26'h3ffffff);
		start_move(1'b1, 26'd0, 1'b1);
		tick(26'h2000000); tick(26'h1ffffff);
		set_min_duration(26'd1);

		send_idle = 14; recv_idle = 56;
		random_phase(500, 2000);
		send_idle = 0; recv_idle = 0;
		drain();  // sender pause until nothing is outstanding
		set_min_duration(26'd60000000);
		send_idle = 56; recv_idle = 14;
		random_phase(500, 3000000);
		set_min_duration(26'd1000);
		send_idle = 0; recv_idle = 0;
		random_phase(500, 4000);
		drain();

		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// ===== cubic_joint_trajectory_unit.f =====
rtl/core/cjt_pkg.sv
rtl/core/cjt_if.sv
rtl/core/cjt_divider.sv
rtl/core/cjt_mac.sv
rtl/core/cubic_joint_trajectory_unit.sv
rtl/core/cjt_checker.sv
sim/cjt_checker.sv
sim/cubic_joint_trajectory_unit_tb.sv
